// ===== hw/rtl/fxgrp_pkg.sv =====
// Shared types, opcodes and helpers for the CHIP-8 Fx-group executor.
// Self-contained; imported by the executor and its port checker.
package fxgrp_pkg;

  localparam int NUM_VREGS_DEF     = 16;
  localparam int MEM_ADDR_BITS_DEF = 12;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);

  localparam int IN_DATA_W = 16;

  // Low instruction byte of the Fx group
  localparam logic [7:0] OP_LD_VX_DT  = 8'h07;
  localparam logic [7:0] OP_LD_VX_KEY = 8'h0A;
  localparam logic [7:0] OP_LD_DT_VX  = 8'h15;
  localparam logic [7:0] OP_LD_ST_VX  = 8'h18;
  localparam logic [7:0] OP_ADD_I_VX  = 8'h1E;
  localparam logic [7:0] OP_LD_FONT   = 8'h29;
  localparam logic [7:0] OP_BCD       = 8'h33;
  localparam logic [7:0] OP_STORE     = 8'h55;
  localparam logic [7:0] OP_LOAD      = 8'h65;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd_t;

  // One finished instruction waiting to be streamed out
  typedef struct packed {
    logic        status;
    logic        bcd;
    logic [7:0]  reg_value;
    logic [15:0] index;
    bcd_t        digits;
  } fx_rec_t;

  function automatic bcd_t to_bcd(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  rem8;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [6:0]  t10;
    bcd_t        res;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem8 = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    rem  = rem8[6:0];
    // x / 10 as (x * 205) >> 11, exact below 100
    prod = 15'(rem) * 15'd205;
    t    = prod[14:11];
    t10  = 7'(t) * 7'd10;
    res.hund = {2'b00, h};
    res.tens = t;
    res.ones = 4'(rem - t10);
    return res;
  endfunction

endpackage

// ===== hw/rtl/chip8_fx_group_executor_unit.sv =====
// CHIP-8 Fx-group executor: V registers in a synchronous RAM, I and timers in flops.
// Depends on fxgrp_pkg.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata: operation, reg_x, key_value
//  out_    | out | out_tvalid/tready   | tdata: status, mem_write, mem_addr, mem_data,
//          |     |                     |        reg_value; tlast: last
//
// One transaction in per cycle while in_tready is high; a result passes the execute
// stage register and is then written into the result queue before it is valid.
// BCD store (0x33) sends three output transactions, one per digit; all others send one.
// Throughput is set by the output beat sequencer and the 4-entry result queue.
// The register RAM is read at acceptance and written from the execute stage in the
// cycle after; a read that meets a write to the same entry is forwarded.
// rst_n clears the registers, timers, index and queue; a stalled output holds.
module chip8_fx_group_executor_unit
  import fxgrp_pkg::*;
#(
  parameter int NUM_VREGS     = NUM_VREGS_DEF,
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
  localparam int OUT_DATA_W   = ((14 + MEM_ADDR_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] operation, [11:8] reg_x, [15:12] key_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status, mem_write, mem_addr, mem_data, reg_value
  output logic                  out_tlast   // last
);

  localparam int VREG_AW = $clog2(NUM_VREGS);
  localparam int PAD_W   = OUT_DATA_W - (14 + MEM_ADDR_BITS);

  logic [7:0] vmem [NUM_VREGS];
  logic [NUM_VREGS-1:0] vld_r;

  logic [7:0]         in_op;
  logic [VREG_AW-1:0] in_x;
  logic [3:0]         in_key;
  logic               in_fire;

  logic               s1_valid_r;
  logic [7:0]         s1_op_r;
  logic [VREG_AW-1:0] s1_x_r;
  logic [3:0]         s1_key_r;
  logic [7:0]         rd_data_r;
  logic               rd_vld_r;

  logic               fwd_valid_r;
  logic [VREG_AW-1:0] fwd_addr_r;
  logic [7:0]         fwd_data_r;

  logic [15:0] index_r, index_nxt;
  logic [7:0]  dt_r, dt_nxt;
  logic [7:0]  st_r, st_nxt;

  logic [7:0] vx_cur, vx_new;
  logic       vwe;
  logic       unknown;
  fx_rec_t    rec;

  fx_rec_t             queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic [1:0]          beat_r;
  fx_rec_t             head;
  logic                out_fire, pop;
  logic [3:0]          digit;
  logic [MEM_ADDR_BITS-1:0] addr;

  assign in_op   = in_tdata[7:0];
  assign in_x    = in_tdata[8 +: VREG_AW];
  assign in_key  = in_tdata[15:12];
  // Credit covers the queue plus the item in the execute stage
  assign in_tready = ((cnt_r + {{QUEUE_AW{1'b0}}, s1_valid_r}) < (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign in_fire = in_tvalid && in_tready;

  // Register RAM: read at acceptance, write from execute stage
  always_ff @(posedge clk) begin
    rd_data_r <= vmem[in_x];
    if (vwe) begin
      vmem[s1_x_r] <= vx_new;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= in_op;
    s1_x_r     <= in_x;
    s1_key_r   <= in_key;
    fwd_addr_r <= s1_x_r;
    fwd_data_r <= vx_new;
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      index_r     <= '0;
      dt_r        <= '0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= in_fire;
      fwd_valid_r <= vwe;
      rd_vld_r    <= vld_r[in_x];
      if (vwe) begin
        vld_r[s1_x_r] <= 1'b1;
      end
      index_r <= index_nxt;
      dt_r    <= dt_nxt;
      st_r    <= st_nxt;
    end
  end

  // Execute stage
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_x_r)) begin
      vx_cur = fwd_data_r;
    end else if (rd_vld_r) begin
      vx_cur = rd_data_r;
    end else begin
      vx_cur = '0;
    end
    vx_new    = vx_cur;
    vwe       = 1'b0;
    unknown   = 1'b0;
    index_nxt = index_r;
    dt_nxt    = dt_r;
    st_nxt    = st_r;
    unique case (s1_op_r) inside
      OP_LD_VX_DT: begin
        vx_new = dt_r;
        vwe    = s1_valid_r;
      end
      OP_LD_VX_KEY: begin
        vx_new = {4'd0, s1_key_r};
        vwe    = s1_valid_r;
      end
      OP_LD_DT_VX: if (s1_valid_r) dt_nxt = vx_cur;
      OP_LD_ST_VX: if (s1_valid_r) st_nxt = vx_cur;
      OP_ADD_I_VX: if (s1_valid_r) index_nxt = index_r + {8'd0, vx_cur};
      OP_BCD, OP_LD_FONT, OP_STORE, OP_LOAD: ;
      default: unknown = 1'b1;
    endcase
    rec.status    = unknown ? STATUS_UNKNOWN : STATUS_OK;
    rec.bcd       = (s1_op_r == OP_BCD);
    rec.reg_value = vx_new;
    rec.index     = index_r;
    rec.digits    = to_bcd(vx_cur);
  end

  // Result queue and beat sequencer
  assign head     = queue[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = !head.bcd || (beat_r == 2'd2);
  assign out_fire   = out_tvalid && out_tready;
  assign pop        = out_fire && out_tlast;
  assign cnt_nxt    = cnt_r + {{QUEUE_AW{1'b0}}, s1_valid_r} - {{QUEUE_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      queue[wr_ptr_r] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      beat_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_valid_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        beat_r   <= '0;
      end else if (out_fire) begin
        beat_r <= beat_r + 1'b1;
      end
    end
  end

  always_comb begin
    case (beat_r)
      2'd0:    digit = head.digits.hund;
      2'd1:    digit = head.digits.tens;
      default: digit = head.digits.ones;
    endcase
    addr = head.index[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(beat_r);
    if (!head.bcd) begin
      digit = '0;
      addr  = '0;
    end
  end

  assign out_tdata = {{PAD_W{1'b0}}, head.reg_value, digit, addr, head.bcd, head.status};

endmodule

// ===== hw/rtl/fxgrp_port_chk.sv =====
// Port-level checker for the Fx-group executor, bound to the top level.
// Depends on fxgrp_pkg.
module fxgrp_port_chk
  import fxgrp_pkg::*;
#(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF,
  localparam int OUT_DATA_W   = ((14 + MEM_ADDR_BITS + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  localparam int DATA_LO = 2 + MEM_ADDR_BITS;

  logic       st_bit, wr_bit;
  logic [3:0] data_f;

  assign st_bit = out_tdata[0];
  assign wr_bit = out_tdata[1];
  assign data_f = out_tdata[DATA_LO +: 4];

  // Unknown operations give a single closing transaction without a write
  a_unknown_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st_bit |-> out_tlast && !wr_bit)
    else $error("unknown-op result carries a write or is not last");

  // Written digits are decimal
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && wr_bit |-> data_f <= 4'd9)
    else $error("BCD digit out of range");

  // A BCD write that is not last is followed by another write of the same run
  a_bcd_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && wr_bit && !out_tlast |=> out_tvalid && wr_bit)
    else $error("BCD run broken");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid straight after reset");

  // Stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

endmodule

bind chip8_fx_group_executor_unit fxgrp_port_chk #(
  .MEM_ADDR_BITS(MEM_ADDR_BITS)
) u_fxgrp_port_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/chip8_fx_group_executor_unit_tb.sv =====
// Testbench for the CHIP-8 Fx-group executor: streams instructions in, predicts
// every result beat from a local copy of V, I and the timers, and checks each one.
// Depends on fxgrp_pkg and chip8_fx_group_executor_unit.
`timescale 1ns / 1ps

module chip8_fx_group_executor_unit_tb;
  import fxgrp_pkg::*;

  localparam int AW          = MEM_ADDR_BITS_DEF;
  localparam int OUT_W       = ((14 + AW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RESET_CYCLES = 9;

  // Bytes outside the Fx group, used to exercise the error status
  localparam logic [7:0] OP_BAD_ZERO = 8'h00;
  localparam logic [7:0] OP_BAD_ONES = 8'hFF;
  localparam logic [7:0] OP_BAD_NEAR = 8'h1F;

  typedef struct packed {
    logic          status;
    logic          mem_write;
    logic [AW-1:0] mem_addr;
    logic [3:0]    mem_data;
    logic [7:0]    reg_value;
    logic          last;
  } fx_beat_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_CADENCE} rx_mode_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [15:0]      in_tdata;   // [7:0] operation, [11:8] reg_x, [15:12] key_value
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // status, mem_write, mem_addr, mem_data, reg_value
  logic             out_tlast;  // last

  // Shadow of the executor state
  logic [7:0]  vreg_shadow [16];
  logic [15:0] index_shadow;
  logic [7:0]  delay_shadow;
  logic [7:0]  sound_shadow;

  fx_beat_t pending_beats[$];
  int       error_count = 0;
  int       cycle_count = 0;

  // Sender and receiver pacing
  int       burst_left    = 0;
  bit       sender_steady = 0;
  int       hold_request  = 0;
  int       hold_left     = 0;
  int       mode_left     = 0;
  rx_mode_t rx_mode       = RX_FREE;

  logic [7:0] known_ops [9] = '{OP_LD_VX_DT, OP_LD_VX_KEY, OP_LD_DT_VX, OP_LD_ST_VX,
                                OP_ADD_I_VX, OP_LD_FONT, OP_BCD, OP_STORE, OP_LOAD};

  chip8_fx_group_executor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic predict_fx_exec(input logic [7:0] op, input logic [3:0] x,
                                 input logic [3:0] key);
    fx_beat_t   b;
    logic [7:0] v;
    int         k;
    b = '0;
    b.last = 1'b1;
    case (op)
      OP_LD_VX_DT:  vreg_shadow[x] = delay_shadow;
      OP_LD_VX_KEY: vreg_shadow[x] = {4'b0000, key};
      OP_LD_DT_VX:  delay_shadow = vreg_shadow[x];
      OP_LD_ST_VX:  sound_shadow = vreg_shadow[x];
      OP_ADD_I_VX:  index_shadow = index_shadow + {8'h00, vreg_shadow[x]};
      OP_LD_FONT, OP_STORE, OP_LOAD: ;
      OP_BCD: begin
        v = vreg_shadow[x];
        for (k = 0; k < 3; k++) begin
          b.status    = STATUS_OK;
          b.mem_write = 1'b1;
          b.mem_addr  = AW'(index_shadow + 16'(k));
          b.mem_data  = (k == 0) ? 4'(v / 100) : (k == 1) ? 4'((v / 10) % 10) : 4'(v % 10);
          b.reg_value = v;
          b.last      = (k == 2);
          pending_beats.push_back(b);
        end
      end
      default: b.status = STATUS_UNKNOWN;
    endcase
    if (op != OP_BCD) begin
      b.reg_value = vreg_shadow[x];
      pending_beats.push_back(b);
    end
  endtask

  // Offer one instruction and hold it until the block takes it
  task automatic send_instr(input logic [7:0] op, input logic [3:0] x,
                            input logic [3:0] key);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {key, x, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_fx_exec(op, x, key);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic check_beat();
    fx_beat_t exp_b;
    fx_beat_t act_b;
    act_b.status    = out_tdata[0];
    act_b.mem_write = out_tdata[1];
    act_b.mem_addr  = out_tdata[2 +: AW];
    act_b.mem_data  = out_tdata[2 + AW +: 4];
    act_b.reg_value = out_tdata[6 + AW +: 8];
    act_b.last      = out_tlast;
    if (pending_beats.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h", $time, act_b);
      error_count++;
    end else begin
      exp_b = pending_beats.pop_front();
      check_field("status", exp_b.status, act_b.status);
      check_field("mem_write", exp_b.mem_write, act_b.mem_write);
      check_field("mem_addr", exp_b.mem_addr, act_b.mem_addr);
      check_field("mem_data", exp_b.mem_data, act_b.mem_data);
      check_field("reg_value", exp_b.reg_value, act_b.reg_value);
      check_field("last", exp_b.last, act_b.last);
    end
  endtask

  // Receiver: check each transaction, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_beat();
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:    out_tready <= 1'b1;
        RX_LIGHT:   out_tready <= ($urandom_range(0, 9) < 7);
        RX_HEAVY:   out_tready <= ($urandom_range(0, 9) < 3);
        RX_CADENCE: out_tready <= (cycle_count % 3 != 0);
      endcase
    end
  end

  task automatic test_directed_ops();
    send_instr(OP_LD_VX_KEY, 4'd0, 4'd15);
    send_instr(OP_LD_VX_KEY, 4'd15, 4'd0);
    send_instr(OP_LD_VX_KEY, 4'd7, 4'd9);
    send_instr(OP_BCD, 4'd0, 4'd0);
    send_instr(OP_BCD, 4'd15, 4'd15);
    send_instr(OP_LD_DT_VX, 4'd0, 4'd0);
    send_instr(OP_LD_VX_DT, 4'd3, 4'd0);
    send_instr(OP_LD_ST_VX, 4'd7, 4'd0);
    send_instr(OP_ADD_I_VX, 4'd0, 4'd0);
    send_instr(OP_BCD, 4'd7, 4'd0);
    // font, store and load bytes do nothing but report success
    send_instr(OP_LD_FONT, 4'd0, 4'd0);
    send_instr(OP_STORE, 4'd15, 4'd0);
    send_instr(OP_LOAD, 4'd3, 4'd0);
    // unknown bytes report the current VX with an error status
    send_instr(OP_BAD_ZERO, 4'd0, 4'd0);
    send_instr(OP_BAD_ONES, 4'd15, 4'd15);
    send_instr(OP_BAD_NEAR, 4'd3, 4'd0);
    send_instr(OP_LD_VX_KEY, 4'd5, 4'd10);
    send_instr(OP_BCD, 4'd5, 4'd0);
    send_instr(OP_LD_DT_VX, 4'd15, 4'd0);
    send_instr(OP_LD_VX_DT, 4'd0, 4'd0);
    send_instr(OP_BCD, 4'd3, 4'd0);
    wait_drained();
  endtask

  // Step I up to the target with V1 = 15 and V2 as the remainder
  task automatic advance_index_to(input logic [15:0] target);
    logic [15:0] gap_left;
    send_instr(OP_LD_VX_KEY, 4'd1, 4'd15);
    while (index_shadow != target) begin
      gap_left = target - index_shadow;
      if (gap_left >= 16'd15) begin
        send_instr(OP_ADD_I_VX, 4'd1, 4'd0);
      end else begin
        send_instr(OP_LD_VX_KEY, 4'd2, gap_left[3:0]);
        send_instr(OP_ADD_I_VX, 4'd2, 4'd0);
      end
    end
  endtask

  // Run a BCD store across a 256-byte boundary so the address carries
  task automatic test_index_carry();
    logic [15:0] target;
    send_instr(OP_LD_VX_KEY, 4'd4, 4'd14);
    target = {index_shadow[15:8], 8'hFE};
    if (target < index_shadow) target = target + 16'd256;
    advance_index_to(target);
    send_instr(OP_BCD, 4'd4, 4'd0);
    send_instr(OP_ADD_I_VX, 4'd1, 4'd0);
    send_instr(OP_BCD, 4'd1, 4'd0);
    wait_drained();
  endtask

  task automatic send_random_instr();
    int         r;
    logic [7:0] op;
    r = $urandom_range(0, 99);
    if (r < 15)      op = 8'($urandom_range(0, 255));
    else if (r < 35) op = OP_LD_VX_KEY;
    else if (r < 55) op = OP_BCD;
    else if (r < 65) op = OP_ADD_I_VX;
    else             op = known_ops[$urandom_range(0, 8)];
    send_instr(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endtask

  // Stop the receiver long enough for the result queue to fill and stall the input
  task automatic test_backlog();
    int n;
    hold_request  = 120;
    sender_steady = 1;
    for (n = 0; n < 20; n++) send_random_instr();
    sender_steady = 0;
    wait_drained();
  endtask

  task automatic test_random_mix();
    int n;
    for (n = 0; n < 50; n++) begin
      send_random_instr();
      if (n == 25) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    int k;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    for (k = 0; k < 16; k++) vreg_shadow[k] = 8'h00;
    index_shadow = 16'h0000;
    delay_shadow = 8'h00;
    sound_shadow = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_backlog();
    test_random_mix();
    test_index_carry();

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fxgrp_pkg.sv
hw/rtl/chip8_fx_group_executor_unit.sv
hw/rtl/fxgrp_port_chk.sv
tb/chip8_fx_group_executor_unit_tb.sv
